>>> rtl/core/sact_pkg.sv
// Shared types, codes and constants of the set-associative cache tag simulator.
`timescale 1ns / 1ps

package sact_pkg;

  // Default sizes of the tag store and the address path
  localparam int MAX_SET_BITS_DEF  = 8;
  localparam int MAX_WAYS_DEF      = 8;
  localparam int ADDRESS_WIDTH_DEF = 64;

  // Field widths of the stream words
  localparam int OP_W        = 2;
  localparam int ADDR_FIELD_W = 64;
  localparam int OUTCOME_W   = 2;
  localparam int TOTAL_W     = 64;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 200;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SET_CFG_W   = 4;
  localparam int OFF_CFG_W   = 6;
  localparam int WAYS_CFG_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  // Access kinds; the fourth code is unused and does nothing
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // Lookup status of one set row
  typedef struct packed {
    logic hit;
    logic free;
  } lkup_t;

endpackage

>>> rtl/core/set_assoc_cache_tag_sim.sv
// Top level of the set-associative cache tag simulator.
`timescale 1ns / 1ps

// Each word on the input stream is one access (load, store or modify) to a byte
// address; each gives one output word with the outcome of its first lookup (hit,
// miss into a free way, or miss with eviction), a flag for the modify's second,
// always hitting part, and the running 64-bit hit, miss and eviction counts, which
// wrap. The set row is read from the tag memory when the access is accepted, then
// compared and written back in the lookup state, after which the next word is
// accepted; a full output register holds the lookup state until the word is taken.
// Each set row carries a valid bit in flip-flops that reset clears at once, so no
// clearing pass is needed. Lines fill the lowest free way; a full set always
// replaces its highest way in use. The user writes configuration through cfg_we,
// cfg_index and cfg_data only while no access is in flight; the block does not enforce it.

module set_assoc_cache_tag_sim
  import sact_pkg::*;
#(
  parameter int MAX_SET_BITS  = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS      = MAX_WAYS_DEF,
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Access stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // operation[1:0], address[65:2], zero fill
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // outcome[1:0], extra_hit[2], hit_total[66:3],
                                          // miss_total[130:67], eviction_total[194:131],
                                          // zero fill
);

  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W = MAX_WAYS * ADDRESS_WIDTH;

  // Configuration registers
  logic [SET_CFG_W-1:0]  set_bits;
  logic [OFF_CFG_W-1:0]  off_bits;
  logic [WAYS_CFG_W-1:0] ways_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= SET_CFG_W'(1);
      off_bits <= OFF_CFG_W'(1);
      ways_cfg <= WAYS_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS: set_bits <= cfg_data[SET_CFG_W-1:0];
        CFG_OFF_BITS: off_bits <= cfg_data[OFF_CFG_W-1:0];
        CFG_WAYS:     ways_cfg <= cfg_data[WAYS_CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  // Associativity clamped to one through the store's way count
  logic [CNT_W-1:0] ways;

  always_comb begin
    if (ways_cfg == '0) begin
      ways = CNT_W'(1);
    end else if (32'(ways_cfg) > MAX_WAYS) begin
      ways = CNT_W'(MAX_WAYS);
    end else begin
      ways = CNT_W'(ways_cfg);
    end
  end

  // Address split of the incoming word
  logic [MAX_SET_BITS-1:0]  in_set;
  logic [ADDRESS_WIDTH-1:0] in_tag;

  sact_addr_split #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_split (
    .address (s_tdata[OP_W+ADDR_FIELD_W-1:OP_W]),
    .set_bits(set_bits),
    .off_bits(off_bits),
    .set_idx (in_set),
    .tag     (in_tag)
  );

  // Control state and the access in flight
  state_t                   state;
  state_t                   state_next;
  logic                     accept;
  logic                     commit;
  logic [OP_W-1:0]          req_op;
  logic [MAX_SET_BITS-1:0]  req_set;
  logic [ADDRESS_WIDTH-1:0] req_tag;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    commit     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= s_tdata[OP_W-1:0];
      req_set <= in_set;
      req_tag <= in_tag;
    end
  end

  // Tag memory and lookup
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] row_tags;
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] new_tags;
  logic [CNT_W-1:0]                       row_fill;
  logic [CNT_W-1:0]                       fill_next;
  logic [WAY_W-1:0]                       victim;
  lkup_t                                  lk;
  logic                                   access_op;
  logic                                   mem_we;

  sact_tag_store #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ROW_W       (ROW_W),
    .CNT_W       (CNT_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(in_set),
    .rd_tags(row_tags),
    .rd_fill(row_fill),
    .wr_en  (mem_we),
    .wr_addr(req_set),
    .wr_tags(new_tags),
    .wr_fill(fill_next)
  );

  sact_lookup #(
    .MAX_WAYS(MAX_WAYS),
    .TAG_W   (ADDRESS_WIDTH),
    .CNT_W   (CNT_W),
    .WAY_W   (WAY_W)
  ) u_lookup (
    .tags     (row_tags),
    .fill     (row_fill),
    .tag      (req_tag),
    .ways     (ways),
    .status   (lk),
    .victim   (victim),
    .fill_next(fill_next)
  );

  assign access_op = (req_op == OP_LOAD) || (req_op == OP_STORE) || (req_op == OP_MODIFY);
  assign mem_we    = commit && access_op && !lk.hit;

  // Row written back with the new tag in the chosen way
  always_comb begin
    new_tags         = row_tags;
    new_tags[victim] = req_tag;
  end

  // Outcome and counter updates of the access in flight
  logic                 is_modify;
  outcome_t             outcome;
  logic [TOTAL_W-1:0]   hit_cnt;
  logic [TOTAL_W-1:0]   miss_cnt;
  logic [TOTAL_W-1:0]   evict_cnt;
  logic [TOTAL_W-1:0]   hit_cnt_next;
  logic [TOTAL_W-1:0]   miss_cnt_next;
  logic [TOTAL_W-1:0]   evict_cnt_next;

  assign is_modify = (req_op == OP_MODIFY);

  always_comb begin
    outcome        = OUT_HIT;
    hit_cnt_next   = hit_cnt;
    miss_cnt_next  = miss_cnt;
    evict_cnt_next = evict_cnt;
    if (access_op) begin
      if (lk.hit) begin
        outcome      = OUT_HIT;
        hit_cnt_next = hit_cnt + (is_modify ? TOTAL_W'(2) : TOTAL_W'(1));
      end else begin
        miss_cnt_next = miss_cnt + TOTAL_W'(1);
        hit_cnt_next  = hit_cnt + (is_modify ? TOTAL_W'(1) : TOTAL_W'(0));
        if (lk.free) begin
          outcome = OUT_FILL;
        end else begin
          outcome        = OUT_EVICT;
          evict_cnt_next = evict_cnt + TOTAL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      evict_cnt <= '0;
    end else if (commit) begin
      hit_cnt   <= hit_cnt_next;
      miss_cnt  <= miss_cnt_next;
      evict_cnt <= evict_cnt_next;
    end
  end

  // Output register
  outcome_t           out_outcome;
  logic               out_extra;
  logic [TOTAL_W-1:0] out_hit;
  logic [TOTAL_W-1:0] out_miss;
  logic [TOTAL_W-1:0] out_evict;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_outcome <= outcome;
      out_extra   <= is_modify;
      out_hit     <= hit_cnt_next;
      out_miss    <= miss_cnt_next;
      out_evict   <= evict_cnt_next;
    end
  end

  assign m_tdata = {
    (OUT_DATA_W - OUTCOME_W - 1 - 3 * TOTAL_W)'(0),
    out_evict, out_miss, out_hit, out_extra, out_outcome
  };

  // Checks on the access sequencing
  a_accept_looks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOK))
    else $error("accepted access did not move to lookup");

  a_write_in_look: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_LOOK) && !lk.hit)
    else $error("tag memory written outside a missing lookup");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("finished access left no result");

  a_evict_counts: assert property (@(posedge clk) disable iff (rst)
    commit && access_op && !lk.hit && !lk.free |=> (evict_cnt == $past(evict_cnt) + TOTAL_W'(1)))
    else $error("eviction not counted");

endmodule

>>> rtl/core/sact_addr_split.sv
// Address split into set index and tag under the configured bit counts.
`timescale 1ns / 1ps

module sact_addr_split
  import sact_pkg::*;
#(
  parameter int MAX_SET_BITS  = MAX_SET_BITS_DEF,
  parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
  input  logic [ADDR_FIELD_W-1:0]  address,
  input  logic [SET_CFG_W-1:0]     set_bits,
  input  logic [OFF_CFG_W-1:0]     off_bits,
  output logic [MAX_SET_BITS-1:0]  set_idx,
  output logic [ADDRESS_WIDTH-1:0] tag
);

  localparam int SB_W = $clog2(MAX_SET_BITS + 1);
  localparam int SH_W = $clog2((1 << OFF_CFG_W) + MAX_SET_BITS);

  logic [SB_W-1:0]          sb;
  logic [ADDRESS_WIDTH-1:0] addr_used;
  logic [ADDRESS_WIDTH-1:0] addr_shr;
  logic [SH_W-1:0]          tag_shift;

  // Set bits saturate at the size of the store
  always_comb begin
    if (32'(set_bits) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits);
    end
  end

  // Offset drops off the bottom, the set index sits above it, the rest is tag
  assign addr_used = address[ADDRESS_WIDTH-1:0];
  assign addr_shr  = addr_used >> off_bits;
  assign set_idx   = addr_shr[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << sb);
  assign tag_shift = SH_W'(off_bits) + SH_W'(sb);
  assign tag       = addr_used >> tag_shift;

endmodule

>>> rtl/core/sact_tag_store.sv
// Set-row memory holding the tags and fill count of each set, with row valid bits.
`timescale 1ns / 1ps

module sact_tag_store
  import sact_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int ROW_W        = 8,
  parameter int CNT_W        = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [MAX_SET_BITS-1:0] rd_addr,
  output logic [ROW_W-1:0]        rd_tags,
  output logic [CNT_W-1:0]        rd_fill,
  input  logic                    wr_en,
  input  logic [MAX_SET_BITS-1:0] wr_addr,
  input  logic [ROW_W-1:0]        wr_tags,
  input  logic [CNT_W-1:0]        wr_fill
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;

  logic [ROW_W+CNT_W-1:0] mem [NUM_SETS];
  logic [NUM_SETS-1:0]    row_vld;
  logic [ROW_W+CNT_W-1:0] rd_row;
  logic                   rd_vld;

  // Row valid bits; a row never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_vld[rd_addr];
      end
    end
  end

  // Memory array with one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_fill, wr_tags};
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  assign rd_tags = rd_row[ROW_W-1:0];
  assign rd_fill = rd_vld ? rd_row[ROW_W+CNT_W-1:ROW_W] : '0;

endmodule

>>> rtl/core/sact_lookup.sv
// Tag compare over one set row and choice of the way to fill or replace.
`timescale 1ns / 1ps

module sact_lookup
  import sact_pkg::*;
#(
  parameter int MAX_WAYS = MAX_WAYS_DEF,
  parameter int TAG_W    = ADDRESS_WIDTH_DEF,
  parameter int CNT_W    = 4,
  parameter int WAY_W    = 3
) (
  input  logic [MAX_WAYS-1:0][TAG_W-1:0] tags,
  input  logic [CNT_W-1:0]               fill,
  input  logic [TAG_W-1:0]               tag,
  input  logic [CNT_W-1:0]               ways,
  output lkup_t                          status,
  output logic [WAY_W-1:0]               victim,
  output logic [CNT_W-1:0]               fill_next
);

  logic [MAX_WAYS-1:0] match;

  // Valid lines form a prefix of the row, so a way is valid below the fill count
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = (CNT_W'(w) < ways) && (CNT_W'(w) < fill) && (tags[w] == tag);
    end
  end

  assign status.hit  = |match;
  assign status.free = fill < ways;

  // A free slot takes the next way; a full set gives up its highest way in use
  always_comb begin
    if (status.free) begin
      victim    = WAY_W'(fill);
      fill_next = fill + CNT_W'(1);
    end else begin
      victim    = WAY_W'(ways - CNT_W'(1));
      fill_next = fill;
    end
  end

endmodule

>>> sim/tb_set_assoc_cache_tag_sim.sv
// Self-checking testbench for the set-associative cache tag simulator.
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_sim;
  import sact_pkg::*;

  localparam int NSETS = 1 << MAX_SET_BITS_DEF;
  localparam int NWAYS = MAX_WAYS_DEF;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 104;
  localparam int POOL_SIZE = 16;

  // Register index with no register behind it, and the access code that does nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [OUTCOME_W-1:0] outcome;
    logic                 extra;
    logic [TOTAL_W-1:0]   hits;
    logic [TOTAL_W-1:0]   misses;
    logic [TOTAL_W-1:0]   evictions;
  } access_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // operation[1:0], address[65:2], zero fill
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // outcome[1:0], extra_hit[2], hit_total[66:3],
                                    // miss_total[130:67], eviction_total[194:131], zero fill

  // Shadow tag store, counters and geometry of the block.
  logic                  line_ok  [NSETS][NWAYS];
  logic [63:0]           line_tag [NSETS][NWAYS];
  logic [TOTAL_W-1:0]    hit_count;
  logic [TOTAL_W-1:0]    miss_count;
  logic [TOTAL_W-1:0]    evict_count;
  logic [SET_CFG_W-1:0]  set_bits_q;
  logic [OFF_CFG_W-1:0]  off_bits_q;
  logic [WAYS_CFG_W-1:0] ways_q;

  access_result_t pending_results[$];
  access_result_t head_result;
  int             errors = 0;
  bit             idle_on = 1'b1;
  int             ready_hold = 0;

  set_assoc_cache_tag_sim dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up long after the slowest correct run would have finished.
  initial begin
    #5_000_000;
    $display("tb_set_assoc_cache_tag_sim: errors");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Set bits saturate at the maximum; the way count is clamped to 1..max.
  function automatic int eff_set_bits();
    return (set_bits_q > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(set_bits_q);
  endfunction

  function automatic int eff_ways();
    if (ways_q == 0) return 1;
    if (ways_q > NWAYS) return NWAYS;
    return int'(ways_q);
  endfunction

  // One lookup and fill of the shadow store.
  function automatic logic [OUTCOME_W-1:0] lookup_line(input logic [63:0] addr);
    int          sb;
    int          ob;
    int          ways;
    int          set;
    int          w;
    logic [63:0] tag;
    sb = eff_set_bits();
    ob = int'(off_bits_q);
    ways = eff_ways();
    set = int'((addr >> ob) & ((64'd1 << sb) - 64'd1));
    tag = (ob + sb < 64) ? (addr >> (ob + sb)) : 64'd0;
    for (w = 0; w < ways; w++) begin
      if (line_ok[set][w] && line_tag[set][w] == tag) begin
        hit_count += 1;
        return OUT_HIT;
      end
    end
    miss_count += 1;
    for (w = 0; w < ways; w++) begin
      if (!line_ok[set][w]) begin
        line_ok[set][w] = 1'b1;
        line_tag[set][w] = tag;
        return OUT_FILL;
      end
    end
    // Full set: the highest way in use is always the victim.
    evict_count += 1;
    line_tag[set][ways-1] = tag;
    line_ok[set][ways-1] = 1'b1;
    return OUT_EVICT;
  endfunction

  function automatic access_result_t predict_access(input logic [OP_W-1:0] op,
                                                    input logic [63:0] addr);
    access_result_t r;
    r.outcome = OUT_HIT;
    r.extra = 1'b0;
    if (op == OP_LOAD || op == OP_STORE) begin
      r.outcome = lookup_line(addr);
    end else if (op == OP_MODIFY) begin
      r.outcome = lookup_line(addr);
      void'(lookup_line(addr));
      r.extra = 1'b1;
    end
    r.hits = hit_count;
    r.misses = miss_count;
    r.evictions = evict_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Sends one access word, with an optional idle burst in front of it.
  task automatic send_access(input logic [OP_W-1:0] op, input logic [63:0] addr);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(10, 1);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {{(IN_DATA_W - OP_W - ADDR_FIELD_W){1'b0}}, addr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_access(op, addr));
  endtask

  // Stops the stream and waits for every outstanding result word.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SET_BITS: set_bits_q = val[SET_CFG_W-1:0];
      CFG_OFF_BITS: off_bits_q = val[OFF_CFG_W-1:0];
      CFG_WAYS:     ways_q = val[WAYS_CFG_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] sb, input logic [CFG_DATA_W-1:0] ob,
                              input logic [CFG_DATA_W-1:0] ways);
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_OFF_BITS, ob);
    write_reg(CFG_WAYS, ways);
  endtask

  // Reset geometry: two sets of one way, two-byte blocks.
  task automatic test_default_geometry();
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, 64'd1);
    send_access(OP_STORE, '1);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
    send_access(OP_NONE, 64'h5555_5555_5555_5555);
  endtask

  // Zero set bits and zero ways: one set holding a single line.
  task automatic test_degenerate_geometry();
    set_geometry(6'd0, 6'd0, 6'd0);
    send_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(OP_LOAD, 64'h5555_5555_5555_5555);
    send_access(OP_MODIFY, 64'h5555_5555_5555_5555);
  endtask

  // Offset and set bits reach the address width, so every tag is zero.
  task automatic test_wide_offset();
    set_geometry(6'd15, 6'd63, 6'd15);
    send_access(OP_LOAD, 64'h8000_0000_0000_0000);
    send_access(OP_STORE, '1);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    set_geometry(6'd8, 6'd56, 6'd8);
    send_access(OP_LOAD, '1);
  endtask

  // Fill, replacement of the top way in use, and lines kept above a smaller way count.
  task automatic test_replacement();
    set_geometry(6'd2, 6'd4, 6'd3);
    send_access(OP_LOAD, 64'd1 << 6);
    send_access(OP_STORE, 64'd2 << 6);
    send_access(OP_LOAD, 64'd3 << 6);
    write_reg(CFG_WAYS, 6'd1);
    send_access(OP_LOAD, 64'd2 << 6);
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_WAYS, 6'd3);
    send_access(OP_LOAD, (64'd3 << 6) | 64'hF);
    send_access(OP_STORE, 64'd4 << 6);
    send_access(OP_MODIFY, 64'd1 << 6);
  endtask

  // Random geometries with accesses drawn mostly from a small pool of blocks.
  task automatic test_random_traffic();
    logic [63:0]      pool[POOL_SIZE];
    logic [63:0]      addr;
    logic [63:0]      low_mask;
    logic [OP_W-1:0]  op;
    int               p;
    int               i;
    int               r;
    int               sb;
    int               ob;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_geometry(6'd1, 6'd1, 6'd8);
        1:       set_geometry(6'd8, 6'd6, 6'd8);
        2:       set_geometry(6'd0, 6'd0, 6'd1);
        3:       set_geometry(6'd15, 6'd63, 6'd15);
        default: set_geometry(($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                       : 6'($urandom_range(15)),
                              ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                       : 6'($urandom_range(12)),
                              ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                       : 6'($urandom_range(15)));
      endcase
      idle_on = (p != PHASES - 1) && ($urandom_range(3) != 0);
      sb = eff_set_bits();
      ob = int'(off_bits_q);
      low_mask = (64'd1 << ob) - 64'd1;
      for (i = 0; i < POOL_SIZE; i++) begin
        pool[i] = (64'($urandom_range(5)) << (ob + sb)) | (64'($urandom_range(3)) << ob)
                | (rand64() & low_mask);
      end
      for (i = 0; i < PHASE_WORDS; i++) begin
        r = $urandom_range(9);
        if (r < 2) begin
          addr = rand64();
        end else if (r < 4) begin
          addr = rand64();
          pool[$urandom_range(POOL_SIZE - 1)] = addr;
        end else begin
          addr = pool[$urandom_range(POOL_SIZE - 1)] ^ (rand64() & low_mask);
        end
        r = $urandom_range(31);
        if (r < 11) op = OP_LOAD;
        else if (r < 22) op = OP_STORE;
        else if (r < 31) op = OP_MODIFY;
        else op = OP_NONE;
        send_access(op, addr);
      end
    end
  endtask

  // Result side: random bursts with ready low, then check each word against the oldest prediction.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_tready = 1'b0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      ready_hold = $urandom_range(9, 0);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no access waiting for it");
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("outcome", 64'(head_result.outcome), 64'(m_tdata[1:0]));
        check_field("extra_hit", 64'(head_result.extra), 64'(m_tdata[2]));
        check_field("hit_total", head_result.hits, m_tdata[66:3]);
        check_field("miss_total", head_result.misses, m_tdata[130:67]);
        check_field("eviction_total", head_result.evictions, m_tdata[194:131]);
      end
    end
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        line_ok[s][w] = 1'b0;
        line_tag[s][w] = '0;
      end
    end
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;
    set_bits_q = 4'd1;
    off_bits_q = 6'd1;
    ways_q = 4'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_geometry();
    test_degenerate_geometry();
    test_wide_offset();
    test_replacement();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_set_assoc_cache_tag_sim: clean");
    end else begin
      $display("tb_set_assoc_cache_tag_sim: errors");
    end
    $finish;
  end

endmodule
